>>> design/smt_pkg.sv
// Package for the sorted multiset table: operation, status, cell command and
// controller state types shared by the interfaces, the cells and the top level.
// Depends on nothing.
`default_nettype none

package smt_pkg;

	// Widths of the fixed payload fields.
	localparam int unsigned ValueW = 32;
	localparam int unsigned CountW = 5;

	// Operation codes carried by an input transfer.
	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_REMOVE_ONE = 2'd1,
		OP_REMOVE_ALL = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	// Status codes carried by a result transfer.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// What every cell of the row does.
	typedef enum logic [1:0] {
		CM_HOLD   = 2'd0,
		CM_INSERT = 2'd1,
		CM_REMOVE = 2'd2
	} cell_mode_t;

	// Command broadcast to the row of cells.
	typedef struct packed {
		cell_mode_t               mode;
		logic signed [ValueW-1:0] value;
	} cell_cmd_t;

	// Controller states.
	typedef enum logic {
		S_IDLE  = 1'b0,
		S_SWEEP = 1'b1
	} state_t;

endpackage

`default_nettype wire

>>> design/smt_in_if.sv
// Input channel of the sorted multiset table: valid/ready with operation and value.
// Depends on smt_pkg.
`default_nettype none

interface smt_in_if;
	logic                             valid;
	logic                             ready;
	smt_pkg::op_t                     op;
	logic signed [smt_pkg::ValueW-1:0] value;

	modport source(output valid, output op, output value, input ready);
	modport sink(input valid, input op, input value, output ready);
endinterface

`default_nettype wire

>>> design/smt_out_if.sv
// Result channel of the sorted multiset table: valid/ready with status and counts.
// Depends on smt_pkg.
`default_nettype none

interface smt_out_if;
	logic                              valid;
	logic                              ready;
	smt_pkg::status_t                  status;
	logic [smt_pkg::CountW-1:0]        removed_count;
	logic [smt_pkg::CountW-1:0]        entry_count;
	logic signed [smt_pkg::ValueW-1:0] smallest;

	modport source(output valid, output status, output removed_count,
		output entry_count, output smallest, input ready);
	modport sink(input valid, input status, input removed_count,
		input entry_count, input smallest, output ready);
endinterface

`default_nettype wire

>>> design/smt_cell.sv
// One cell of the sorted row: holds one entry, compares it with the broadcast
// value and shifts toward either neighbor on insert or remove. Depends on smt_pkg.
`default_nettype none

module smt_cell (
	input  wire logic                              clk,
	input  wire smt_pkg::cell_cmd_t                cmd,
	input  wire logic                              valid,
	input  wire logic                              left_lt,
	input  wire logic signed [smt_pkg::ValueW-1:0] left_data,
	input  wire logic signed [smt_pkg::ValueW-1:0] right_data,
	output logic signed [smt_pkg::ValueW-1:0]      data,
	output logic signed [smt_pkg::ValueW-1:0]      data_next,
	output logic                                   lt,
	output logic                                   eq
);
	import smt_pkg::*;

	logic signed [ValueW-1:0] data_q;

	// Compare the held entry with the broadcast value.
	assign lt   = valid && (data_q < cmd.value);
	assign eq   = valid && (data_q == cmd.value);
	assign data = data_q;

	// Entries below the position stay; the rest move one place.
	always_comb begin
		data_next = data_q;
		case (cmd.mode)
			CM_INSERT: begin
				if (!lt) begin
					data_next = left_lt ? cmd.value : left_data;
				end
			end
			CM_REMOVE: begin
				if (!lt) begin
					data_next = right_data;
				end
			end
			default: begin
				data_next = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

endmodule

`default_nettype wire

>>> design/sorted_multiset_table.sv
// Top level of the sorted multiset table: row of comparing cells, occupancy
// counter, operation controller and result register.
// Depends on smt_pkg, smt_in_if, smt_out_if and smt_cell.
//
//   channel  modport  payload                                      moves
//   req      sink     op, value                                    one operation
//   rsp      source   status, removed_count, entry_count, smallest one result
//
// Insert, remove one and clear write their result to the output register at the
// edge the operation is accepted.
// Remove all walks the row one occurrence per cycle: after the transfer, each
// matching entry is removed by a shift of the cell chain, and the sweep ends by
// writing the result once no match is found and the result register is free.
// A new operation is accepted while idle and the result register is free or
// being drained in that cycle. Reset clears the occupancy and the result valid.
`default_nettype none

module sorted_multiset_table #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	smt_in_if.sink    req,
	smt_out_if.source rsp
);
	import smt_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       removed_q, removed_d;
	logic signed [ValueW-1:0] value_q;
	cell_cmd_t           cmd;

	logic signed [ValueW-1:0] cell_data [DEPTH];
	logic signed [ValueW-1:0] cell_next [DEPTH];
	logic [DEPTH-1:0]    cell_lt;
	logic [DEPTH-1:0]    cell_eq;
	logic [DEPTH-1:0]    cell_valid;
	logic                found;
	logic                out_free;
	logic                res_load;
	status_t             res_status;
	logic [CW-1:0]       res_removed;

	logic [CW+CountW-1:0] removed_ext;
	logic [CW+CountW-1:0] count_ext;

	assign found    = |cell_eq;
	assign out_free = !rsp.valid || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;

	// Cell row; left end sees the new value, right end its own data.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] Index = CW'(i);
		logic                     left_lt;
		logic signed [ValueW-1:0] left_data;
		logic signed [ValueW-1:0] right_data;

		assign cell_valid[i] = Index < count_q;
		if (i == 0) begin : g_first
			assign left_lt   = 1'b1;
			assign left_data = cmd.value;
		end else begin : g_inner_left
			assign left_lt   = cell_lt[i-1];
			assign left_data = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner_right
			assign right_data = cell_data[i+1];
		end

		smt_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (cell_valid[i]),
			.left_lt    (left_lt),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i]),
			.data_next  (cell_next[i]),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i])
		);
	end

	// Next state of the controller.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready && req.op == OP_REMOVE_ALL) begin
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (!found && out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Cell command, counters and result of the controller.
	always_comb begin
		cmd.mode    = CM_HOLD;
		cmd.value   = req.value;
		count_d     = count_q;
		removed_d   = removed_q;
		res_load    = 1'b0;
		res_status  = ST_OK;
		res_removed = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					unique case (req.op)
						OP_INSERT: begin
							res_load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								res_status = ST_FULL;
							end else begin
								cmd.mode = CM_INSERT;
								count_d  = count_q + 1'b1;
							end
						end
						OP_REMOVE_ONE: begin
							res_load = 1'b1;
							if (found) begin
								cmd.mode    = CM_REMOVE;
								count_d     = count_q - 1'b1;
								res_removed = CW'(1);
							end else begin
								res_status = ST_NOT_FOUND;
							end
						end
						OP_REMOVE_ALL: begin
							removed_d = '0;
						end
						OP_CLEAR: begin
							res_load    = 1'b1;
							res_removed = count_q;
							count_d     = '0;
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
				end
			end
			S_SWEEP: begin
				cmd.value = value_q;
				if (found) begin
					cmd.mode  = CM_REMOVE;
					count_d   = count_q - 1'b1;
					removed_d = removed_q + 1'b1;
				end else if (out_free) begin
					res_load    = 1'b1;
					res_removed = removed_q;
					res_status  = (removed_q == '0) ? ST_NOT_FOUND : ST_OK;
				end
			end
			default: begin
				cmd.mode = CM_HOLD;
			end
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			removed_q <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
		end
	end

	// The value under removal is held for the sweep.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			value_q <= req.value;
		end
	end

	// Counts are reported modulo the field width.
	assign removed_ext = {{CountW{1'b0}}, res_removed};
	assign count_ext   = {{CountW{1'b0}}, count_d};

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (res_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp.status        <= res_status;
			rsp.removed_count <= removed_ext[CountW-1:0];
			rsp.entry_count   <= count_ext[CountW-1:0];
			rsp.smallest      <= (count_d != '0) ? cell_next[0] : '0;
		end
	end

endmodule

`default_nettype wire
